FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shorthand for the clocked implication checks used in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: sv/dfr_pkg.sv
// ---------------------------------------------------------------------------
// Delimited frame receiver package
// Shared types, register map, phase and error codes.
// ---------------------------------------------------------------------------
`default_nettype none

package dfr_pkg;

   localparam int DEFAULT_BUFFER_BYTES = 128;
   localparam int HEADER_BYTES         = 6;

   // Configuration port
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      REG_START_DELIM = 3'd0,
      REG_END_DELIM   = 3'd1,
      REG_TYPE_REQ    = 3'd2,
      REG_TYPE_CNF    = 3'd3,
      REG_TYPE_RSP    = 3'd4,
      REG_TYPE_IND    = 3'd5
   } reg_index_type;

   localparam logic [7:0] RESET_START_DELIM = 8'd2;
   localparam logic [7:0] RESET_END_DELIM   = 8'd3;
   localparam logic [7:0] RESET_TYPE_REQ    = 8'd82;
   localparam logic [7:0] RESET_TYPE_CNF    = 8'd67;
   localparam logic [7:0] RESET_TYPE_RSP    = 8'd114;
   localparam logic [7:0] RESET_TYPE_IND    = 8'd105;

   typedef enum logic [2:0] {
      PH_WAIT_START = 3'd0,
      PH_WAIT_TYPE  = 3'd1,
      PH_HEADER     = 3'd2,
      PH_DATA       = 3'd3,
      PH_WAIT_END   = 3'd4
   } phase_type;

   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_TYPE   = 3'd1;
   localparam logic [2:0] ERR_SUM    = 3'd2;
   localparam logic [2:0] ERR_LONG   = 3'd3;
   localparam logic [2:0] ERR_NO_END = 3'd4;

   typedef struct packed {
      logic [7:0] start_delim;
      logic [7:0] end_delim;
      logic [7:0] type_req;
      logic [7:0] type_cnf;
      logic [7:0] type_rsp;
      logic [7:0] type_ind;
   } cfg_type;

   // A received byte with its classification, as queued between front and back.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       is_start;
      logic       is_end;
      logic       type_ok;
   } cls_type;

   typedef struct packed {
      logic       store_valid;
      logic       store_bank;
      logic [6:0] store_index;
      logic       frame_done;
      logic [7:0] frame_length;
      logic       done_bank;
      logic [2:0] error_code;
   } result_type;

endpackage

`default_nettype wire

FILE: sv/dfr_csr.sv
// ---------------------------------------------------------------------------
// Frame receiver control registers
// APB-style register file holding delimiters and accepted packet types.
// ---------------------------------------------------------------------------
`default_nettype none

module dfr_csr import dfr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   reg_index_type index;
   logic          wr_en;
   logic [7:0]    rd_value;

   assign index  = reg_index_type'(paddr[ADDR_W-1:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_delim <= RESET_START_DELIM;
         cfg_ff.end_delim   <= RESET_END_DELIM;
         cfg_ff.type_req    <= RESET_TYPE_REQ;
         cfg_ff.type_cnf    <= RESET_TYPE_CNF;
         cfg_ff.type_rsp    <= RESET_TYPE_RSP;
         cfg_ff.type_ind    <= RESET_TYPE_IND;
      end else if (wr_en) begin
         unique case (index)
            REG_START_DELIM: cfg_ff.start_delim <= pwdata[7:0];
            REG_END_DELIM:   cfg_ff.end_delim   <= pwdata[7:0];
            REG_TYPE_REQ:    cfg_ff.type_req    <= pwdata[7:0];
            REG_TYPE_CNF:    cfg_ff.type_cnf    <= pwdata[7:0];
            REG_TYPE_RSP:    cfg_ff.type_rsp    <= pwdata[7:0];
            REG_TYPE_IND:    cfg_ff.type_ind    <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_START_DELIM: rd_value = cfg_ff.start_delim;
         REG_END_DELIM:   rd_value = cfg_ff.end_delim;
         REG_TYPE_REQ:    rd_value = cfg_ff.type_req;
         REG_TYPE_CNF:    rd_value = cfg_ff.type_cnf;
         REG_TYPE_RSP:    rd_value = cfg_ff.type_rsp;
         REG_TYPE_IND:    rd_value = cfg_ff.type_ind;
         default:         rd_value = 8'd0;
      endcase
   end

   assign prdata = {{(DATA_W-8){1'b0}}, rd_value};

endmodule

`default_nettype wire

FILE: sv/dfr_classify.sv
// ---------------------------------------------------------------------------
// Frame receiver front end
// Compares each received byte against the delimiters and packet types.
// ---------------------------------------------------------------------------
`default_nettype none

module dfr_classify import dfr_pkg::*; (
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output cls_type    cls
);

   always_comb begin
      cls.rx_byte  = rx_byte;
      cls.is_start = (rx_byte == cfg.start_delim);
      cls.is_end   = (rx_byte == cfg.end_delim);
      cls.type_ok  = (rx_byte == cfg.type_req) || (rx_byte == cfg.type_cnf) ||
                     (rx_byte == cfg.type_rsp) || (rx_byte == cfg.type_ind);
   end

endmodule

`default_nettype wire

FILE: sv/dfr_queue.sv
// ---------------------------------------------------------------------------
// Frame receiver byte queue
// Two-entry queue that decouples the front end from the frame parser.
// ---------------------------------------------------------------------------
`default_nettype none

module dfr_queue import dfr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cls_type push_data,
   output logic    push_ready,
   output logic    pop_valid,
   output cls_type pop_data,
   input  logic    pop
);

   cls_type    entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       push;

   assign push_ready = (count_ff != 2'd2);
   assign push       = push_valid && push_ready;
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: sv/dfr_parser.sv
// ---------------------------------------------------------------------------
// Frame receiver parser
// Frame state machine with store addressing and a registered result stage.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dfr_parser import dfr_pkg::*; #(
   parameter int BUFFER_BYTES = DEFAULT_BUFFER_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  cls_type    head,
   output logic       head_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

   localparam int NEED_W = $clog2(BUFFER_BYTES + 1);
   localparam int CNT_W  = (NEED_W > 8) ? NEED_W : 8;
   localparam logic [16:0] LIMIT    = 17'(BUFFER_BYTES);
   localparam logic [16:0] OVERHEAD = 17'(HEADER_BYTES + 1);

   phase_type        phase_ff,  phase_in;
   logic [CNT_W-1:0] idx_ff,    idx_in;
   logic [CNT_W-1:0] exp_ff,    exp_in;
   logic [7:0]       sum_ff,    sum_in;
   logic [7:0]       len_lo_ff, len_lo_in;
   logic [7:0]       len_hi_ff, len_hi_in;
   logic             bank_ff,   bank_in;
   logic             rsp_valid_ff;
   result_type       rsp_ff;
   result_type       res;
   logic [15:0]      payload;
   logic [16:0]      total;
   logic [CNT_W:0]   data_reach;
   logic [7:0]       b;

   assign head_pop   = head_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp        = rsp_ff;
   assign b          = head.rx_byte;
   assign payload    = {len_hi_ff, len_lo_ff};
   assign total      = {1'b0, payload} + OVERHEAD;
   assign data_reach = {1'b0, idx_ff} + (CNT_W+1)'(2);

   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      exp_in    = exp_ff;
      sum_in    = sum_ff;
      len_lo_in = len_lo_ff;
      len_hi_in = len_hi_ff;
      bank_in   = bank_ff;
      res       = '0;

      unique case (phase_ff)
         PH_WAIT_START: begin
            if (head.is_start) begin
               res.store_valid = 1'b1;
               res.store_bank  = bank_ff;
               res.store_index = 7'd0;
               idx_in          = CNT_W'(1);
               sum_in          = 8'd0;
               phase_in        = PH_WAIT_TYPE;
            end
         end
         PH_WAIT_TYPE: begin
            if (!head.type_ok) begin
               res.error_code = ERR_TYPE;
               phase_in       = PH_WAIT_START;
            end else begin
               res.store_valid = 1'b1;
               res.store_bank  = bank_ff;
               res.store_index = idx_ff[6:0];
               idx_in          = idx_ff + CNT_W'(1);
               sum_in          = sum_ff + b;
               phase_in        = PH_HEADER;
            end
         end
         PH_HEADER: begin
            if (idx_ff == CNT_W'(3)) begin
               len_lo_in = b;
            end
            if (idx_ff == CNT_W'(4)) begin
               len_hi_in = b;
            end
            res.store_valid = 1'b1;
            res.store_bank  = bank_ff;
            res.store_index = idx_ff[6:0];
            idx_in          = idx_ff + CNT_W'(1);
            // The checksum byte is the last header byte; it is stored either way.
            if (idx_ff == CNT_W'(HEADER_BYTES - 1)) begin
               exp_in = CNT_W'(total);
               if (sum_ff != b) begin
                  res.error_code = ERR_SUM;
                  phase_in       = PH_WAIT_START;
               end else if (total > LIMIT) begin
                  res.error_code = ERR_LONG;
                  phase_in       = PH_WAIT_START;
               end else if (payload == 16'd0) begin
                  phase_in = PH_WAIT_END;
               end else begin
                  phase_in = PH_DATA;
               end
            end else begin
               sum_in = sum_ff + b;
            end
         end
         PH_DATA: begin
            res.store_valid = 1'b1;
            res.store_bank  = bank_ff;
            res.store_index = idx_ff[6:0];
            idx_in          = idx_ff + CNT_W'(1);
            if (data_reach >= {1'b0, exp_ff}) begin
               phase_in = PH_WAIT_END;
            end
         end
         PH_WAIT_END: begin
            if (head.is_end) begin
               res.store_valid  = 1'b1;
               res.store_bank   = bank_ff;
               res.store_index  = idx_ff[6:0];
               res.frame_done   = 1'b1;
               res.frame_length = exp_ff[7:0];
               res.done_bank    = bank_ff;
               idx_in           = idx_ff + CNT_W'(1);
               bank_in          = ~bank_ff;
            end else begin
               res.error_code = ERR_NO_END;
            end
            phase_in = PH_WAIT_START;
         end
         default: begin
            phase_in = PH_WAIT_START;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT_START;
         idx_ff    <= '0;
         exp_ff    <= '0;
         sum_ff    <= 8'd0;
         len_lo_ff <= 8'd0;
         len_hi_ff <= 8'd0;
         bank_ff   <= 1'b0;
      end else if (head_pop) begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         exp_ff    <= exp_in;
         sum_ff    <= sum_in;
         len_lo_ff <= len_lo_in;
         len_hi_ff <= len_hi_in;
         bank_ff   <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (head_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         rsp_ff <= res;
      end
   end

   `ASSERT_IMPLIES(a_done_clean, clock, reset, rsp_valid_ff && rsp_ff.frame_done, rsp_ff.store_valid && (rsp_ff.error_code == ERR_NONE) && (rsp_ff.done_bank == rsp_ff.store_bank))
   `ASSERT_IMPLIES(a_drop_unstored, clock, reset, rsp_valid_ff && ((rsp_ff.error_code == ERR_TYPE) || (rsp_ff.error_code == ERR_NO_END)), !rsp_ff.store_valid)
   `ASSERT_IMPLIES(a_data_in_frame, clock, reset, phase_ff == PH_DATA, (idx_ff < exp_ff) && ({1'b0, exp_ff} <= (CNT_W+1)'(BUFFER_BYTES)))
   `ASSERT_NEXT(a_bank_flip, clock, reset, head_pop && (phase_ff == PH_WAIT_END) && head.is_end, bank_ff != $past(bank_ff))

endmodule

`default_nettype wire

FILE: sv/delimited_frame_receiver_pingpong_top.sv
// ---------------------------------------------------------------------------
// Delimited frame receiver with ping-pong store addressing
// Parses delimited frames with header checksum and reports store addresses.
// ---------------------------------------------------------------------------
//   Channel  Ports   Moves
//   request  req_*   one received link byte (req_rx_byte)
//   result   rsp_*   store address, frame completion and error code per byte
//   control  csr_*   APB-style access to delimiters and packet types
//
// One request is taken per clock while the two-entry queue has room; each
// yields one result through a queue entry and then the result register.
// Requests keep flowing while the result side stalls until the queue fills;
// the parser advances only when its result register is free or being taken.
// Reset is synchronous and leaves the block ready for a request at once.
// ---------------------------------------------------------------------------
`default_nettype none

module delimited_frame_receiver_pingpong_top import dfr_pkg::*; #(
   parameter int BUFFER_BYTES = DEFAULT_BUFFER_BYTES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_store_valid,
   output logic              rsp_store_bank,
   output logic [6:0]        rsp_store_index,
   output logic              rsp_frame_done,
   output logic [7:0]        rsp_frame_length,
   output logic              rsp_done_bank,
   output logic [2:0]        rsp_error_code,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   cfg_type    cfg;
   cls_type    cls;
   cls_type    head;
   logic       head_valid;
   logic       head_pop;
   result_type rsp;

   dfr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   dfr_classify u_classify (
      .rx_byte (req_rx_byte),
      .cfg     (cfg),
      .cls     (cls)
   );

   dfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_data  (cls),
      .push_ready (req_ready),
      .pop_valid  (head_valid),
      .pop_data   (head),
      .pop        (head_pop)
   );

   dfr_parser #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   assign rsp_store_valid  = rsp.store_valid;
   assign rsp_store_bank   = rsp.store_bank;
   assign rsp_store_index  = rsp.store_index;
   assign rsp_frame_done   = rsp.frame_done;
   assign rsp_frame_length = rsp.frame_length;
   assign rsp_done_bank    = rsp.done_bank;
   assign rsp_error_code   = rsp.error_code;

endmodule

`default_nettype wire
